>>> src/fba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg
// Shared widths, operation codes and controller/datapath interface types for
// the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int TOTAL_W = 13;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_MFREE = 2'd2;
    localparam logic [1:0] OP_MUSED = 2'd3;

    typedef struct packed {
        logic accept;
        logic div;
        logic base;
        logic rd;
        logic modify;
        logic advance;
        logic zero_rd;
        logic zero_wr;
        logic fail;
        logic load_out;
        logic clear_wr;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       more;
        logic       in_map;
        logic       has_zero;
        logic       clr_last;
    } t_status;

endpackage
`default_nettype wire

>>> src/frame_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: S_IDLE accepts a transaction; S_DONE loads the output register.
//   allocate: S_DIV, then S_READ/S_MOD per word scanned; free: S_DIV, S_BASE, one
//   S_READ/S_MOD; mark-used, mark-free: S_DIV, S_BASE, S_READ/S_MOD per word from the
//   word of the first frame up to the region end, then S_ZRD/S_ZMOD for mark-free.
// Flow: one transaction at a time, each word by a read-modify-write.
// Reset: a clearing pass writes all ones to every map word before S_IDLE.
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit page-frame allocator over a one-bit-per-frame usage map.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
    parameter int NUM_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire  [fba_pkg::TOTAL_W-1:0]  i_cfg_wr_data,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [1:0]                   i_op,
    input  wire  [fba_pkg::IDX_W-1:0]    i_frame_index,
    input  wire  [fba_pkg::CNT_W-1:0]    i_region_count,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic                         o_ok,
    output logic [fba_pkg::IDX_W-1:0]    o_allocated_frame,
    output logic                         o_double_free
);

    fba_pkg::t_cmd    cmd;
    fba_pkg::t_status status;

    fba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (cmd),
        .i_status (status)
    );

    fba_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_op              (i_op),
        .i_frame_index     (i_frame_index),
        .i_region_count    (i_region_count),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_ok              (o_ok),
        .o_allocated_frame (o_allocated_frame),
        .o_double_free     (o_double_free)
    );

endmodule
`default_nettype wire

>>> src/fba_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_dp
// Datapath: usage map memory, word/bit address arithmetic, first-zero search,
// region masks, result and output registers.
// ----------------------------------------------------------------------------
module fba_dp #(
    parameter int NUM_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_wr_en,
    input  wire  [fba_pkg::TOTAL_W-1:0]    i_cfg_wr_data,
    input  wire  [1:0]                     i_op,
    input  wire  [fba_pkg::IDX_W-1:0]      i_frame_index,
    input  wire  [fba_pkg::CNT_W-1:0]      i_region_count,
    input  fba_pkg::t_cmd                  i_cmd,
    output fba_pkg::t_status               o_status,
    output logic                           o_ok,
    output logic [fba_pkg::IDX_W-1:0]      o_allocated_frame,
    output logic                           o_double_free
);

    localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int FW        = ($clog2(NUM_FRAMES) > 14) ? $clog2(NUM_FRAMES) + 1 : 15;
    // frame_index / WORD_BITS as a multiply by a rounded-up reciprocal
    localparam int DK        = fba_pkg::IDX_W + BW;
    localparam int DM        = (2 ** DK + WORD_BITS - 1) / WORD_BITS;
    localparam int DMW       = fba_pkg::IDX_W + 1;
    localparam int PW        = fba_pkg::IDX_W + DMW;

    localparam logic [FW-1:0] NF     = FW'(NUM_FRAMES);
    localparam logic [FW-1:0] WB_F   = FW'(WORD_BITS);
    localparam logic [AW-1:0] LAST_W = AW'(MAP_WORDS - 1);

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    logic [fba_pkg::TOTAL_W-1:0] r_total;
    logic [AW-1:0]               r_clr;
    logic [1:0]                  r_op;
    logic [fba_pkg::IDX_W-1:0]   r_idx;
    logic [FW-1:0]               r_end;
    logic [fba_pkg::IDX_W-1:0]   r_q;
    logic [AW-1:0]               r_word;
    logic [FW-1:0]               r_base;
    logic [BW-1:0]               r_bit;
    logic [WORD_BITS-1:0]        r_rdata;
    logic                        r_ok;
    logic [fba_pkg::IDX_W-1:0]   r_frame;
    logic                        r_dbl;
    logic                        r_o_ok;
    logic [fba_pkg::IDX_W-1:0]   r_o_frame;
    logic                        r_o_dbl;

    logic [FW-1:0]        lim;
    logic [FW-1:0]        end_sum;
    logic [FW-1:0]        end_clip;
    logic [PW-1:0]        prod;
    logic [FW-1:0]        n_base;
    logic                 has_zero;
    logic [BW-1:0]        zpos;
    logic [FW-1:0]        f_hit;
    logic                 hit;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_bit;
    logic [WORD_BITS-1:0] alloc_bit;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [AW-1:0]        raddr;

    assign lim      = (FW'(r_total) > NF) ? NF : FW'(r_total);
    assign end_sum  = FW'(i_frame_index) + FW'(i_region_count);
    assign end_clip = (end_sum > NF) ? NF : end_sum;
    assign prod     = PW'(r_idx) * PW'(DM);
    assign n_base   = FW'(FW'(r_q) * WB_F);

    // lowest zero bit of the word just read
    always_comb begin
        has_zero = 1'b0;
        zpos     = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!r_rdata[b]) begin
                has_zero = 1'b1;
                zpos     = BW'(b);
            end
        end
    end

    assign f_hit = r_base + FW'(zpos);
    assign hit   = has_zero && (f_hit < lim);

    // bits of the current word that fall inside the clipped region
    always_comb begin
        logic [FW-1:0] fb;
        mask = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            fb      = r_base + FW'(b);
            mask[b] = (fb >= FW'(r_idx)) && (fb < r_end);
        end
    end

    assign free_bit  = WORD_BITS'(1) << r_bit;
    assign alloc_bit = WORD_BITS'(1) << zpos;

    always_comb begin
        we    = 1'b0;
        waddr = r_word;
        wdata = r_rdata;
        if (i_cmd.clear_wr) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = '1;
        end else if (i_cmd.zero_wr) begin
            we    = 1'b1;
            waddr = '0;
            wdata = r_rdata | WORD_BITS'(1);
        end else if (i_cmd.modify) begin
            case (r_op)
                fba_pkg::OP_ALLOC: begin
                    we    = hit;
                    wdata = r_rdata | alloc_bit;
                end
                fba_pkg::OP_FREE: begin
                    we    = 1'b1;
                    wdata = r_rdata & ~free_bit;
                end
                fba_pkg::OP_MFREE: begin
                    we    = 1'b1;
                    wdata = r_rdata & ~mask;
                end
                fba_pkg::OP_MUSED: begin
                    we    = 1'b1;
                    wdata = r_rdata | mask;
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    assign raddr = i_cmd.zero_rd ? '0 : r_word;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd || i_cmd.zero_rd) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= fba_pkg::TOTAL_RESET;
            r_clr   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_total <= i_cfg_wr_data;
            end
            if (i_cmd.clear_wr) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_idx   <= i_frame_index;
            r_end   <= end_clip;
            r_word  <= '0;
            r_base  <= '0;
            r_ok    <= 1'b1;
            r_frame <= '0;
            r_dbl   <= 1'b0;
        end
        if (i_cmd.div) begin
            r_q <= fba_pkg::IDX_W'(prod >> DK);
        end
        if (i_cmd.base) begin
            r_base <= n_base;
            r_word <= AW'(r_q);
            r_bit  <= BW'(FW'(r_idx) - n_base);
        end
        if (i_cmd.advance) begin
            r_word <= r_word + AW'(1);
            r_base <= r_base + WB_F;
        end
        if (i_cmd.fail) begin
            r_ok <= 1'b0;
        end
        if (i_cmd.modify) begin
            if (r_op == fba_pkg::OP_ALLOC) begin
                if (hit) begin
                    r_frame <= f_hit[fba_pkg::IDX_W-1:0];
                end else if (has_zero) begin
                    r_ok <= 1'b0;
                end
            end else if (r_op == fba_pkg::OP_FREE) begin
                r_dbl <= ~r_rdata[r_bit];
            end
        end
        if (i_cmd.load_out) begin
            r_o_ok    <= r_ok;
            r_o_frame <= r_frame;
            r_o_dbl   <= r_dbl;
        end
    end

    always_comb begin
        o_status.op       = r_op;
        o_status.more     = (r_op == fba_pkg::OP_ALLOC) ? (r_base < lim) : (r_base < r_end);
        o_status.in_map   = FW'(r_idx) < NF;
        o_status.has_zero = has_zero;
        o_status.clr_last = (r_clr == LAST_W);
    end

    assign o_ok              = r_o_ok;
    assign o_allocated_frame = r_o_frame;
    assign o_double_free     = r_o_dbl;

endmodule
`default_nettype wire

>>> src/fba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ctrl
// Controller: sequences the map clearing pass, the per-word read-modify-write
// loop for each operation, and the output handoff.
// ----------------------------------------------------------------------------
module fba_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  wire               i_stall,
    output fba_pkg::t_cmd     o_cmd,
    input  fba_pkg::t_status  i_status
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_BASE  = 9'b000001000,
        S_READ  = 9'b000010000,
        S_MOD   = 9'b000100000,
        S_ZRD   = 9'b001000000,
        S_ZMOD  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                // allocate scans from word 0 and needs no address split
                if (i_status.op == fba_pkg::OP_ALLOC) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.div = 1'b1;
                    n_state   = S_BASE;
                end
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                if (i_status.op == fba_pkg::OP_FREE) begin
                    if (i_status.in_map) begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_MOD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_status.more) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_MOD;
                end else if (i_status.op == fba_pkg::OP_ALLOC) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else if (i_status.op == fba_pkg::OP_MFREE) begin
                    n_state = S_ZRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOD: begin
                o_cmd.modify = 1'b1;
                if (i_status.op == fba_pkg::OP_ALLOC) begin
                    if (i_status.has_zero) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_READ;
                    end
                end else if (i_status.op == fba_pkg::OP_FREE) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_ZRD: begin
                o_cmd.zero_rd = 1'b1;
                n_state       = S_ZMOD;
            end
            S_ZMOD: begin
                // frame 0 stays reserved after a mark-free
                o_cmd.zero_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule
`default_nettype wire
